>>> rtl/core/bucketed_priority_fifo_queue_defines.svh
// Assertion macros used by the RTL of the bucketed priority queue
`ifndef BUCKETED_PRIORITY_FIFO_QUEUE_DEFINES_SVH
`define BUCKETED_PRIORITY_FIFO_QUEUE_DEFINES_SVH

`ifndef SYNTH

// Check a condition at every clock edge outside reset
`define BPQ_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define BPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BPQ_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define BPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/core/bpq_pkg.sv
package bpq_pkg;

   // Defaults for the top-level parameters
   localparam int POOL_DEPTH_DEF  = 256;
   localparam int VALUE_WIDTH_DEF = 32;

   // Priority levels are fixed by the 4-bit level fields
   localparam int LEVEL_COUNT = 16;
   localparam int LEVEL_W     = $clog2(LEVEL_COUNT);
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 2;

   typedef logic [LEVEL_W-1:0]  level_type;
   typedef logic [FUNC_W-1:0]   func_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Request operations
   localparam func_type FUNC_ENQUEUE = 2'd0;
   localparam func_type FUNC_DEQUEUE = 2'd1;
   localparam func_type FUNC_QUERY   = 2'd2;

   // Response status codes
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;
   localparam status_type STATUS_RANGE = 2'd3;

   // Register map
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOWEST_LEVEL = 2'd0;
   localparam level_type LOWEST_LEVEL_RESET = 4'd15;

   // Classified request handed from the front to the back
   typedef struct packed {
      func_type  op;
      logic      range_err;
      level_type level;
   } cmd_type;

   // Lowest set bit of the level mask, zero when none is set
   function automatic level_type first_level(input logic [LEVEL_COUNT-1:0] mask);
      level_type idx;
      idx = '0;
      for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
         if (mask[i]) begin
            idx = level_type'(i);
         end
      end
      return idx;
   endfunction

endpackage

>>> rtl/core/bpq_if.sv
// Request channel
interface bpq_req_if #(
   parameter int VALUE_WIDTH = bpq_pkg::VALUE_WIDTH_DEF
);
   import bpq_pkg::*;

   logic                   valid;
   logic                   ready;
   func_type               func;
   logic [VALUE_WIDTH-1:0] item_value;
   level_type              item_level;

   modport source (output valid, output func, output item_value, output item_level,
                   input ready);
   modport sink   (input valid, input func, input item_value, input item_level,
                   output ready);
endinterface

// Response channel
interface bpq_rsp_if #(
   parameter int VALUE_WIDTH = bpq_pkg::VALUE_WIDTH_DEF,
   parameter int POOL_DEPTH  = bpq_pkg::POOL_DEPTH_DEF
);
   import bpq_pkg::*;

   logic                              valid;
   logic                              ready;
   status_type                        status;
   logic [VALUE_WIDTH-1:0]            removed_value;
   logic [VALUE_WIDTH-1:0]            head_value;
   level_type                         head_level;
   logic [$clog2(POOL_DEPTH+1)-1:0]   occupancy;
   logic                              is_empty;

   modport source (output valid, output status, output removed_value, output head_value,
                   output head_level, output occupancy, output is_empty, input ready);
   modport sink   (input valid, input status, input removed_value, input head_value,
                   input head_level, input occupancy, input is_empty, output ready);
endinterface

>>> rtl/core/bpq_ram.sv
module bpq_ram #(
   parameter int WIDTH = bpq_pkg::VALUE_WIDTH_DEF,
   parameter int DEPTH = bpq_pkg::POOL_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one word, read one word with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/core/bpq_front.sv
module bpq_front #(
   parameter int VALUE_WIDTH = bpq_pkg::VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bpq_pkg::level_type     lowest_level,
   bpq_req_if.sink                req_chan,
   output logic                   cmd_valid,
   input  logic                   cmd_ready,
   output bpq_pkg::cmd_type       cmd,
   output logic [VALUE_WIDTH-1:0] cmd_value
);
   import bpq_pkg::*;

   localparam int QDEPTH = 2;
   localparam int QPW    = $clog2(QDEPTH);
   localparam int QFW    = $clog2(QDEPTH + 1);
   localparam logic [QFW-1:0] QFULL = QFW'(QDEPTH);

   cmd_type                cmd_q_ff [QDEPTH];
   logic [VALUE_WIDTH-1:0] val_q_ff [QDEPTH];
   logic [QPW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QFW-1:0]         fill_ff, fill_in;
   cmd_type                new_cmd;
   logic                   push, pop;

   // Classify the incoming request
   always_comb begin
      new_cmd = '0;
      new_cmd.level = req_chan.item_level;
      case (req_chan.func)
         FUNC_ENQUEUE: new_cmd.op = FUNC_ENQUEUE;
         FUNC_DEQUEUE: new_cmd.op = FUNC_DEQUEUE;
         default:      new_cmd.op = FUNC_QUERY;
      endcase
      new_cmd.range_err = (new_cmd.op == FUNC_ENQUEUE) && (req_chan.item_level > lowest_level);
   end

   assign req_chan.ready = (fill_ff != QFULL);
   assign push           = req_chan.valid && req_chan.ready;
   assign cmd_valid      = (fill_ff != '0);
   assign pop            = cmd_valid && cmd_ready;
   assign cmd            = cmd_q_ff[rd_ptr_ff];
   assign cmd_value      = val_q_ff[rd_ptr_ff];

   // Advance the queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Hold the classified request until the back takes it
   always_ff @(posedge clock) begin
      if (push) begin
         cmd_q_ff[wr_ptr_ff] <= new_cmd;
         val_q_ff[wr_ptr_ff] <= req_chan.item_value;
      end
   end

endmodule

>>> rtl/core/bpq_back.sv
`include "bucketed_priority_fifo_queue_defines.svh"

module bpq_back #(
   parameter int POOL_DEPTH  = bpq_pkg::POOL_DEPTH_DEF,
   parameter int VALUE_WIDTH = bpq_pkg::VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  bpq_pkg::cmd_type       cmd,
   input  logic [VALUE_WIDTH-1:0] cmd_value,
   bpq_rsp_if.source              rsp_chan
);
   import bpq_pkg::*;

   localparam int AW = $clog2(POOL_DEPTH);
   localparam int OW = $clog2(POOL_DEPTH + 1);
   localparam logic [OW-1:0] FULL_COUNT = OW'(POOL_DEPTH);

   localparam logic [1:0] BK_IDLE   = 2'd0;
   localparam logic [1:0] BK_UPDATE = 2'd1;
   localparam logic [1:0] BK_HEAD   = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [AW-1:0]          heads_ff [LEVEL_COUNT];
   logic [AW-1:0]          heads_in [LEVEL_COUNT];
   logic [AW-1:0]          tails_ff [LEVEL_COUNT];
   logic [AW-1:0]          tails_in [LEVEL_COUNT];
   logic [LEVEL_COUNT-1:0] nonempty_ff, nonempty_in;
   logic [OW-1:0]          count_ff, count_in;
   logic [OW-1:0]          fresh_ff, fresh_in;
   logic [AW-1:0]          rec_head_ff, rec_head_in;

   // Request in flight
   func_type               op_ff, op_in;
   status_type             status_ff, status_in;
   logic [AW-1:0]          node_ff, node_in;
   level_type              top_ff, top_in;
   logic                   last_ff, last_in;
   logic                   use_rec_ff, use_rec_in;
   logic [VALUE_WIDTH-1:0] removed_ff, removed_in;
   logic                   head_any_ff, head_any_in;
   level_type              head_level_ff, head_level_in;

   // Response register
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [VALUE_WIDTH-1:0] rsp_removed_ff, rsp_removed_in;
   logic [VALUE_WIDTH-1:0] rsp_head_value_ff, rsp_head_value_in;
   level_type              rsp_head_level_ff, rsp_head_level_in;
   logic [OW-1:0]          rsp_occ_ff, rsp_occ_in;
   logic                   rsp_empty_ff, rsp_empty_in;

   // Memory ports
   logic                   val_we, val_re;
   logic [AW-1:0]          val_wa, val_ra;
   logic [VALUE_WIDTH-1:0] val_wd, val_rd;
   logic                   link_we, link_re;
   logic [AW-1:0]          link_wa, link_ra, link_wd, link_rd;

   // Lookups
   level_type              top_now, top_nx, heads_idx, tails_idx;
   logic [AW-1:0]          head_rd, tail_rd, alloc_node;
   logic                   use_rec, deq_ok, enq_ok;
   logic [LEVEL_COUNT-1:0] clear_mask, nonempty_nx;
   status_type             new_status;

   bpq_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(POOL_DEPTH)) u_values (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_wa),
      .wr_data (val_wd),
      .rd_en   (val_re),
      .rd_addr (val_ra),
      .rd_data (val_rd)
   );

   bpq_ram #(.WIDTH(AW), .DEPTH(POOL_DEPTH)) u_links (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_en   (link_re),
      .rd_addr (link_ra),
      .rd_data (link_rd)
   );

   assign cmd_ready = (state_ff == BK_IDLE);

   // Front of the queue before and after the pending removal
   assign top_now = first_level(nonempty_ff);
   assign deq_ok  = (op_ff == FUNC_DEQUEUE) && (status_ff == STATUS_OK);
   assign enq_ok  = (op_ff == FUNC_ENQUEUE) && (status_ff == STATUS_OK);

   always_comb begin
      clear_mask = '0;
      if (deq_ok && last_ff) begin
         clear_mask[top_ff] = 1'b1;
      end
   end

   assign nonempty_nx = nonempty_ff & ~clear_mask;
   assign top_nx      = first_level(nonempty_nx);
   assign heads_idx   = (state_ff == BK_IDLE) ? top_now : top_nx;
   assign tails_idx   = (cmd.op == FUNC_ENQUEUE) ? cmd.level : top_now;
   assign head_rd     = heads_ff[heads_idx];
   assign tail_rd     = tails_ff[tails_idx];

   // Recycled nodes first, then nodes never handed out
   assign use_rec    = (fresh_ff != count_ff);
   assign alloc_node = use_rec ? rec_head_ff : fresh_ff[AW-1:0];

   // Status of the request at the head of the command queue
   always_comb begin
      case (cmd.op)
         FUNC_ENQUEUE: begin
            if (cmd.range_err) begin
               new_status = STATUS_RANGE;
            end else if (count_ff == FULL_COUNT) begin
               new_status = STATUS_FULL;
            end else begin
               new_status = STATUS_OK;
            end
         end
         default: new_status = (count_ff == '0) ? STATUS_EMPTY : STATUS_OK;
      endcase
   end

   // Sequencer: issue, update links, fetch the new front value
   always_comb begin
      state_in          = state_ff;
      heads_in          = heads_ff;
      tails_in          = tails_ff;
      nonempty_in       = nonempty_ff;
      count_in          = count_ff;
      fresh_in          = fresh_ff;
      rec_head_in       = rec_head_ff;
      op_in             = op_ff;
      status_in         = status_ff;
      node_in           = node_ff;
      top_in            = top_ff;
      last_in           = last_ff;
      use_rec_in        = use_rec_ff;
      removed_in        = removed_ff;
      head_any_in       = head_any_ff;
      head_level_in     = head_level_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_removed_in    = rsp_removed_ff;
      rsp_head_value_in = rsp_head_value_ff;
      rsp_head_level_in = rsp_head_level_ff;
      rsp_occ_in        = rsp_occ_ff;
      rsp_empty_in      = rsp_empty_ff;
      val_we            = 1'b0;
      val_wa            = alloc_node;
      val_wd            = cmd_value;
      val_re            = 1'b0;
      val_ra            = head_rd;
      link_we           = 1'b0;
      link_wa           = tail_rd;
      link_wd           = alloc_node;
      link_re           = 1'b0;
      link_ra           = head_rd;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               op_in      = cmd.op;
               status_in  = new_status;
               top_in     = top_now;
               last_in    = (head_rd == tail_rd);
               use_rec_in = use_rec;
               node_in    = (cmd.op == FUNC_DEQUEUE) ? head_rd : alloc_node;
               link_re    = 1'b1;
               link_ra    = (cmd.op == FUNC_ENQUEUE) ? rec_head_ff : head_rd;
               val_re     = (cmd.op == FUNC_DEQUEUE);
               // Append at the tail of the level
               if (cmd.op == FUNC_ENQUEUE && new_status == STATUS_OK) begin
                  val_we = 1'b1;
                  if (nonempty_ff[cmd.level]) begin
                     link_we = 1'b1;
                  end else begin
                     heads_in[cmd.level] = alloc_node;
                  end
                  tails_in[cmd.level]    = alloc_node;
                  nonempty_in[cmd.level] = 1'b1;
                  count_in               = count_ff + 1'b1;
                  if (!use_rec) begin
                     fresh_in = fresh_ff + 1'b1;
                  end
               end
               state_in = BK_UPDATE;
            end
         end
         BK_UPDATE: begin
            if (enq_ok && use_rec_ff) begin
               rec_head_in = link_rd;
            end
            removed_in = '0;
            // Unlink the head node and return it to the recycled list
            if (deq_ok) begin
               removed_in  = val_rd;
               nonempty_in = nonempty_nx;
               if (!last_ff) begin
                  heads_in[top_ff] = link_rd;
               end
               link_we     = 1'b1;
               link_wa     = node_ff;
               link_wd     = rec_head_ff;
               rec_head_in = node_ff;
               count_in    = count_ff - 1'b1;
            end
            val_re        = 1'b1;
            val_ra        = (deq_ok && !last_ff) ? link_rd : head_rd;
            head_any_in   = (nonempty_nx != '0);
            head_level_in = top_nx;
            state_in      = BK_HEAD;
         end
         BK_HEAD: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = status_ff;
               rsp_removed_in    = removed_ff;
               rsp_head_value_in = head_any_ff ? val_rd : '0;
               rsp_head_level_in = head_any_ff ? head_level_ff : '0;
               rsp_occ_in        = count_ff;
               rsp_empty_in      = (count_ff == '0);
               state_in          = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         heads_ff     <= '{default: '0};
         tails_ff     <= '{default: '0};
         nonempty_ff  <= '0;
         count_ff     <= '0;
         fresh_ff     <= '0;
         rec_head_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heads_ff     <= heads_in;
         tails_ff     <= tails_in;
         nonempty_ff  <= nonempty_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         rec_head_ff  <= rec_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff             <= op_in;
      status_ff         <= status_in;
      node_ff           <= node_in;
      top_ff            <= top_in;
      last_ff           <= last_in;
      use_rec_ff        <= use_rec_in;
      removed_ff        <= removed_in;
      head_any_ff       <= head_any_in;
      head_level_ff     <= head_level_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_removed_ff    <= rsp_removed_in;
      rsp_head_value_ff <= rsp_head_value_in;
      rsp_head_level_ff <= rsp_head_level_in;
      rsp_occ_ff        <= rsp_occ_in;
      rsp_empty_ff      <= rsp_empty_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.removed_value = rsp_removed_ff;
   assign rsp_chan.head_value    = rsp_head_value_ff;
   assign rsp_chan.head_level    = rsp_head_level_ff;
   assign rsp_chan.occupancy     = rsp_occ_ff;
   assign rsp_chan.is_empty      = rsp_empty_ff;

   `BPQ_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= FULL_COUNT, "count over depth")
   `BPQ_ASSERT_ALWAYS(a_fresh_covers, clock, reset, fresh_ff >= count_ff, "recycle underflow")
   `BPQ_ASSERT_ALWAYS(a_empty_match, clock, reset, (~|count_ff) == (~|nonempty_ff), "empty mismatch")
   `BPQ_ASSERT_NEXT(a_issue, clock, reset, cmd_valid && cmd_ready, state_ff == BK_UPDATE, "no issue")

endmodule

>>> rtl/core/bucketed_priority_fifo_queue.sv
// Channel    Direction  Contents
// req_chan   in         func, item_value, item_level (valid/ready)
// rsp_chan   out        status, removed_value, head_value, head_level, occupancy,
//                       is_empty (valid/ready)
// csr_*      in/out     APB register port, lowest_level at byte address 0
//
// Each request passes through three back-end states: issue with the link and value
// reads, link update, then the read of the new front value from the value RAM.
// A two-entry request queue keeps accepting while a response waits in the output
// register. Reset is synchronous and takes effect at once: nodes never handed out
// come from a counter, so the pool memories need no clearing pass.
module bucketed_priority_fifo_queue #(
   parameter int POOL_DEPTH  = bpq_pkg::POOL_DEPTH_DEF,
   parameter int VALUE_WIDTH = bpq_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   bpq_req_if.sink                              req_chan,
   bpq_rsp_if.source                            rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bpq_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [bpq_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [bpq_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import bpq_pkg::*;

   level_type              lowest_level_ff, lowest_level_in;
   logic                   cmd_valid, cmd_ready;
   cmd_type                cmd;
   logic [VALUE_WIDTH-1:0] cmd_value;

   // Register write on the access phase
   always_comb begin
      lowest_level_in = lowest_level_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_LOWEST_LEVEL) begin
         lowest_level_in = csr_pwdata[LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_level_ff <= LOWEST_LEVEL_RESET;
      end else begin
         lowest_level_ff <= lowest_level_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_LOWEST_LEVEL) ? CSR_DATA_W'(lowest_level_ff) : '0;

   bpq_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .lowest_level (lowest_level_ff),
      .req_chan     (req_chan),
      .cmd_valid    (cmd_valid),
      .cmd_ready    (cmd_ready),
      .cmd          (cmd),
      .cmd_value    (cmd_value)
   );

   bpq_back #(.POOL_DEPTH(POOL_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .cmd_value (cmd_value),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bpq_pkg::*;

   localparam int VALUE_W      = VALUE_WIDTH_DEF;
   localparam int POOL         = POOL_DEPTH_DEF;
   localparam int NODE_W       = $clog2(POOL);
   localparam int COUNT_W      = $clog2(POOL + 1);
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;

   // Spare operation code, handled by the block as a query
   localparam func_type FUNC_SPARE = 2'd3;

   typedef struct packed {
      func_type           func;
      logic [VALUE_W-1:0] value;
      level_type          level;
   } queue_request_type;

   typedef struct packed {
      status_type         status;
      logic [VALUE_W-1:0] removed_value;
      logic [VALUE_W-1:0] head_value;
      level_type          head_level;
      logic [COUNT_W-1:0] occupancy;
      logic               is_empty;
   } queue_report_type;

   logic clock;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bpq_req_if req_if ();
   bpq_rsp_if rsp_if ();

   bucketed_priority_fifo_queue dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow copy of the queue: node pool, free list and per-level FIFOs
   logic [VALUE_W-1:0]     node_store [POOL];
   logic [NODE_W-1:0]      node_next  [POOL];
   logic [NODE_W-1:0]      level_head [LEVEL_COUNT];
   logic [NODE_W-1:0]      level_tail [LEVEL_COUNT];
   logic [LEVEL_COUNT-1:0] level_busy;
   logic [NODE_W-1:0]      free_node;
   int                     held_count;
   level_type              level_limit;

   queue_request_type request_backlog [$];
   queue_report_type  awaited_reports [$];
   queue_request_type on_offer;

   int send_gap_max;
   int stall_max;
   int send_wait;
   int hold_left;
   int mismatch_count;
   int cycle_count;

   // Chain every node onto the free list and clear all levels
   function automatic void clear_queue_model();
      for (int i = 0; i < POOL; i++) begin
         node_store[i] = '0;
         node_next[i]  = NODE_W'((i + 1) % POOL);
      end
      for (int l = 0; l < LEVEL_COUNT; l++) begin
         level_head[l] = '0;
         level_tail[l] = '0;
      end
      level_busy  = '0;
      free_node   = '0;
      held_count  = 0;
      level_limit = LOWEST_LEVEL_RESET;
   endfunction

   // Most urgent non-empty level, LEVEL_COUNT when nothing is stored
   function automatic int front_level();
      for (int l = 0; l < LEVEL_COUNT; l++) begin
         if (level_busy[l]) begin
            return l;
         end
      end
      return LEVEL_COUNT;
   endfunction

   // Apply one request to the shadow queue and return the report it gives
   function automatic queue_report_type track_queue_op(queue_request_type r);
      queue_report_type  rep;
      int                front;
      logic [NODE_W-1:0] node;
      rep = '0;
      rep.status = STATUS_OK;
      if (r.func == FUNC_ENQUEUE) begin
         if (r.level > level_limit) begin
            rep.status = STATUS_RANGE;
         end else if (held_count >= POOL) begin
            rep.status = STATUS_FULL;
         end else begin
            node             = free_node;
            free_node        = node_next[node];
            node_store[node] = r.value;
            if (level_busy[r.level]) begin
               node_next[level_tail[r.level]] = node;
            end else begin
               level_head[r.level] = node;
            end
            level_tail[r.level] = node;
            level_busy[r.level] = 1'b1;
            held_count++;
         end
      end else if (r.func == FUNC_DEQUEUE) begin
         front = front_level();
         if (held_count == 0 || front >= LEVEL_COUNT) begin
            rep.status = STATUS_EMPTY;
         end else begin
            node = level_head[front];
            rep.removed_value = node_store[node];
            if (node == level_tail[front]) begin
               level_busy[front] = 1'b0;
            end else begin
               level_head[front] = node_next[node];
            end
            node_next[node] = free_node;
            free_node       = node;
            held_count--;
         end
      end else if (held_count == 0) begin
         rep.status = STATUS_EMPTY;
      end
      front = front_level();
      if (front < LEVEL_COUNT) begin
         rep.head_value = node_store[level_head[front]];
         rep.head_level = level_type'(front);
      end
      rep.occupancy = COUNT_W'(held_count);
      rep.is_empty  = (held_count == 0);
      return rep;
   endfunction

   function automatic queue_request_type request_of(func_type f, level_type l,
                                                    logic [VALUE_W-1:0] v);
      queue_request_type r;
      r.func  = f;
      r.level = l;
      r.value = v;
      return r;
   endfunction

   // Random request; stray_pct is the share of levels drawn over the full range
   function automatic queue_request_type draw_request(int enq_pct, int deq_pct,
                                                      int stray_pct);
      queue_request_type r;
      int roll;
      roll = $urandom_range(0, 99);
      r.value = $urandom();
      if ($urandom_range(0, 15) == 0) begin
         r.value = ($urandom_range(0, 1) != 0) ? '1 : '0;
      end
      if ($urandom_range(0, 99) < stray_pct) begin
         r.level = level_type'($urandom_range(0, LEVEL_COUNT - 1));
      end else begin
         r.level = level_type'($urandom_range(0, level_limit));
      end
      if (roll < enq_pct) begin
         r.func = FUNC_ENQUEUE;
      end else if (roll < enq_pct + deq_pct) begin
         r.func = FUNC_DEQUEUE;
      end else begin
         r.func = ($urandom_range(0, 3) == 0) ? FUNC_SPARE : FUNC_QUERY;
      end
      return r;
   endfunction

   // Idle cycles after one transfer, with many back-to-back transfers
   function automatic int draw_pause(int max_gap);
      if (max_gap == 0 || $urandom_range(0, 2) != 0) begin
         return 0;
      end
      return $urandom_range(0, max_gap);
   endfunction

   // Hold until every queued request is sent and every report has come back
   task automatic wait_quiet();
      while (request_backlog.size() != 0 || req_if.valid || awaited_reports.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Write lowest_level with junk in the upper bits, then read it back
   task automatic write_level_limit(level_type lim);
      logic [CSR_DATA_W-1:0] word;
      word      = $urandom();
      word[3:0] = lim;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_LOWEST_LEVEL;
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      level_limit = lim;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(lim)) begin
         $error("lowest_level: expected %0d, got %0d", lim, csr_prdata);
         mismatch_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Drain, reprogram the level limit, then queue a batch of random requests
   task automatic run_phase(level_type lim, int sgap, int stall, int count,
                            int enq_pct, int deq_pct, int stray_pct);
      wait_quiet();
      write_level_limit(lim);
      send_gap_max = sgap;
      stall_max    = stall;
      for (int i = 0; i < count; i++) begin
         request_backlog.push_back(draw_request(enq_pct, deq_pct, stray_pct));
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Give up if the run hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("run exceeded %0d cycles with %0d reports outstanding",
                CYCLE_LIMIT, awaited_reports.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Request driver: predict on acceptance, then offer the next request
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            awaited_reports.push_back(track_queue_op(on_offer));
            send_wait = draw_pause(send_gap_max);
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_wait != 0) begin
               req_if.valid <= 1'b0;
               send_wait--;
            end else if (request_backlog.size() != 0) begin
               on_offer = request_backlog.pop_front();
               req_if.valid      <= 1'b1;
               req_if.func       <= on_offer.func;
               req_if.item_value <= on_offer.value;
               req_if.item_level <= on_offer.level;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Report monitor: compare against the oldest prediction, then maybe stall
   always @(posedge clock) begin
      queue_report_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (awaited_reports.size() == 0) begin
               $error("report with no request outstanding");
               mismatch_count++;
            end else begin
               want = awaited_reports.pop_front();
               if (rsp_if.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                  mismatch_count++;
               end
               if (rsp_if.removed_value !== want.removed_value) begin
                  $error("removed_value: expected %0h, got %0h",
                         want.removed_value, rsp_if.removed_value);
                  mismatch_count++;
               end
               if (rsp_if.head_value !== want.head_value) begin
                  $error("head_value: expected %0h, got %0h",
                         want.head_value, rsp_if.head_value);
                  mismatch_count++;
               end
               if (rsp_if.head_level !== want.head_level) begin
                  $error("head_level: expected %0d, got %0d",
                         want.head_level, rsp_if.head_level);
                  mismatch_count++;
               end
               if (rsp_if.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d",
                         want.occupancy, rsp_if.occupancy);
                  mismatch_count++;
               end
               if (rsp_if.is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_if.is_empty);
                  mismatch_count++;
               end
            end
            hold_left = draw_pause(stall_max);
         end
         if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      // Drive every input to a known value before the first edge
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.func       = FUNC_QUERY;
      req_if.item_value = '0;
      req_if.item_level = '0;
      rsp_if.ready      = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      mismatch_count    = 0;
      cycle_count       = 0;
      send_gap_max      = 16;
      stall_max         = 16;
      clear_queue_model();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty queue: query, spare code and dequeue all report empty
      request_backlog.push_back(request_of(FUNC_QUERY, 4'd15, 32'hFFFF_FFFF));
      request_backlog.push_back(request_of(FUNC_SPARE, 4'd0, 32'h0));
      request_backlog.push_back(request_of(FUNC_DEQUEUE, 4'd9, $urandom()));
      // Extreme values and levels, two requests sharing level 0
      request_backlog.push_back(request_of(FUNC_ENQUEUE, 4'd15, 32'hFFFF_FFFF));
      request_backlog.push_back(request_of(FUNC_ENQUEUE, 4'd0, 32'h0000_0000));
      request_backlog.push_back(request_of(FUNC_ENQUEUE, 4'd7, 32'hA5A5_A5A5));
      request_backlog.push_back(request_of(FUNC_ENQUEUE, 4'd0, 32'h5A5A_5A5A));
      request_backlog.push_back(request_of(FUNC_ENQUEUE, 4'd15, 32'h0000_0001));
      request_backlog.push_back(request_of(FUNC_QUERY, 4'd3, $urandom()));
      request_backlog.push_back(request_of(FUNC_SPARE, 4'd12, $urandom()));
      request_backlog.push_back(request_of(FUNC_DEQUEUE, 4'd0, $urandom()));
      request_backlog.push_back(request_of(FUNC_DEQUEUE, 4'd15, $urandom()));
      request_backlog.push_back(request_of(FUNC_DEQUEUE, 4'd5, $urandom()));
      request_backlog.push_back(request_of(FUNC_ENQUEUE, 4'd9, $urandom()));
      request_backlog.push_back(request_of(FUNC_ENQUEUE, 4'd12, $urandom()));

      // Lower the limit to 0 while levels above it still hold elements
      wait_quiet();
      write_level_limit(4'd0);
      request_backlog.push_back(request_of(FUNC_ENQUEUE, 4'd1, $urandom()));
      request_backlog.push_back(request_of(FUNC_ENQUEUE, 4'd15, $urandom()));
      request_backlog.push_back(request_of(FUNC_ENQUEUE, 4'd0, 32'hC3C3_3C3C));
      request_backlog.push_back(request_of(FUNC_DEQUEUE, 4'd2, $urandom()));
      request_backlog.push_back(request_of(FUNC_QUERY, 4'd0, $urandom()));
      for (int i = 0; i < 5; i++) begin
         request_backlog.push_back(request_of(FUNC_DEQUEUE, level_type'($urandom()), $urandom()));
      end

      // Random mixes under several limits and idling regimes
      run_phase(4'd15, 16, 16, 60, 45, 35, 10);
      run_phase(level_type'($urandom_range(1, 14)), 0, 0, 40, 45, 35, 25);
      // Fill the pool to the brim, then hit it while full
      run_phase(4'd10, 16, 0, 280, 100, 0, 0);
      run_phase(4'd10, 8, 8, 40, 70, 10, 100);
      // Drain past empty
      run_phase(level_type'($urandom_range(1, 14)), 0, 16, 300, 0, 95, 20);
      run_phase(4'd0, 16, 16, 40, 50, 30, 30);
      run_phase(4'd15, 0, 0, 40, 45, 35, 10);

      // Let the last reports arrive and watch for strays
      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_reports.size() != 0) begin
         $error("%0d reports never arrived", awaited_reports.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
